// ===== src/bba_pkg.sv =====
// Shared widths, codes and controller/datapath interface types for the bitmap allocator.
package bba_pkg;

    localparam int INDEX_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = 5;
    localparam int INDEX_SPACE = 4096;
    localparam int MAX_WORDS   = INDEX_SPACE / WORD_W;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic in_ready;
        logic cfg_ready;
        logic cap_item;
        logic grp_load;
        logic rd_alloc;
        logic rd_item;
        logic commit;
        logic sw_rd;
        logic sw_acc;
    } t_cmd;

    typedef struct packed {
        logic in_beat;
        logic cfg_beat;
        logic new_alloc;
        logic out_free;
        logic sw_last;
    } t_stat;

endpackage

// ===== src/block_bitmap_allocator.sv =====
// Top level of the first-fit block bitmap allocator.
//
//  channel  direction  handshake             beat payload
//  request  in         i_valid / o_stall     i_func, i_block_index
//  result   out        o_valid / i_stall     o_granted_index, o_status,
//                                            o_is_allocated, o_free_count
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_data (block count)
//
// Allocate: capture, summary group search, word select and read, update; free,
// query and mark: capture, word read, update. Each request reads one 32-bit
// bitmap word on the single memory port; a granted allocate, or an in-range
// free or mark, writes it back. After reset and each config write, a sweep of
// the bitmap words rebuilds the free count; o_stall is high then. A held result
// (i_stall high) does not block the next request until its update.
module block_bitmap_allocator #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bba_pkg::FUNC_W-1:0]        i_func,
    input  logic [bba_pkg::INDEX_W-1:0]       i_block_index,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bba_pkg::INDEX_W-1:0]       o_granted_index,
    output logic [bba_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_is_allocated,
    output logic [bba_pkg::COUNT_W-1:0]       o_free_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bba_pkg::COUNT_W-1:0]       i_cfg_data
);
    import bba_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_block_index   (i_block_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_is_allocated  (o_is_allocated),
        .o_free_count    (o_free_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

endmodule

// ===== src/bba_ctrl.sv =====
// Sequencing state machine for the bitmap allocator: recount sweep and request steps.
module bba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd  o_cmd
);
    import bba_pkg::*;

    typedef enum logic [6:0] {
        S_CNT_RD  = 7'b0000001,
        S_CNT_ACC = 7'b0000010,
        S_IDLE    = 7'b0000100,
        S_SRCH    = 7'b0001000,
        S_SEL     = 7'b0010000,
        S_RD      = 7'b0100000,
        S_MOD     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CNT_RD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.cfg_ready = (r_state == S_IDLE) || (r_state == S_CNT_RD)
                          || (r_state == S_CNT_ACC);
        // a config beat takes the idle slot; the request waits for the sweep
        o_cmd.in_ready  = (r_state == S_IDLE) && !i_stat.cfg_beat;
        case (r_state)
            S_CNT_RD: begin
                o_cmd.sw_rd = 1'b1;
                n_state     = S_CNT_ACC;
            end
            S_CNT_ACC: begin
                o_cmd.sw_acc = 1'b1;
                n_state      = i_stat.sw_last ? S_IDLE : S_CNT_RD;
            end
            S_IDLE: begin
                if (i_stat.in_beat) begin
                    o_cmd.cap_item = 1'b1;
                    n_state        = i_stat.new_alloc ? S_SRCH : S_RD;
                end
            end
            S_SRCH: begin
                o_cmd.grp_load = 1'b1;
                n_state        = S_SEL;
            end
            S_SEL: begin
                o_cmd.rd_alloc = 1'b1;
                n_state        = S_MOD;
            end
            S_RD: begin
                o_cmd.rd_item = 1'b1;
                n_state       = S_MOD;
            end
            S_MOD: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CNT_RD;
            end
        endcase
        // new block count: recount free blocks from the bitmap
        if (i_stat.cfg_beat) begin
            n_state = S_CNT_RD;
        end
    end

endmodule

// ===== src/bba_dp.sv =====
// Datapath of the bitmap allocator: bitmap memory, summary, counters and result register.
module bba_dp #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bba_pkg::t_cmd                     i_cmd,
    output bba_pkg::t_stat                    o_stat,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bba_pkg::FUNC_W-1:0]        i_func,
    input  logic [bba_pkg::INDEX_W-1:0]       i_block_index,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bba_pkg::INDEX_W-1:0]       o_granted_index,
    output logic [bba_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_is_allocated,
    output logic [bba_pkg::COUNT_W-1:0]       o_free_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bba_pkg::COUNT_W-1:0]       i_cfg_data
);
    import bba_pkg::*;

    localparam int NW_RAW = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int NW     = (NW_RAW > MAX_WORDS) ? MAX_WORDS : NW_RAW;
    localparam int WA     = (NW > 1) ? $clog2(NW) : 1;
    localparam int NG     = (NW + WORD_W - 1) / WORD_W;
    localparam logic [COUNT_W-1:0] LIM_MAX =
        COUNT_W'((NUM_BLOCKS < INDEX_SPACE) ? NUM_BLOCKS : INDEX_SPACE);

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] k;
        k = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (v[j]) begin
                k = BIT_W'(j);
            end
        end
        return k;
    endfunction

    logic [WORD_W-1:0]   mem [NW];
    logic [WORD_W-1:0]   r_rdata;
    logic                r_rd_valid;
    logic [NW-1:0]       r_wvalid;
    logic [NW-1:0]       r_nonfull;
    logic [COUNT_W-1:0]  r_limit;
    logic [COUNT_W-1:0]  r_free;
    logic [COUNT_W-1:0]  r_used;
    logic [WA-1:0]       r_sw_addr;
    logic [FUNC_W-1:0]   r_func;
    logic [INDEX_W-1:0]  r_idx;
    logic [WA-1:0]       r_word_addr;
    logic                r_found;
    logic [NG-1:0]       r_grp_any;
    logic [BIT_W-1:0]    r_grp_low [NG];
    logic                r_o_valid;
    logic [INDEX_W-1:0]  r_granted;
    logic [STATUS_W-1:0] r_status;
    logic                r_is_alloc;
    logic [COUNT_W-1:0]  r_o_free;

    logic [NG*WORD_W-1:0] sum_pad;
    logic                 sel_any;
    logic [6:0]           sel_w7;
    logic [WA-1:0]        idx_word;
    logic [WA-1:0]        rd_addr;
    logic                 rd_en;
    logic [WORD_W-1:0]    word;
    logic [COUNT_W-1:0]   eff_limit;

    // sweep
    logic [COUNT_W-1:0]   sw_lo;
    logic [COUNT_W-1:0]   sw_hi;
    logic [COUNT_W-1:0]   sw_rem;
    logic [WORD_W-1:0]    sw_mask;
    logic [BIT_W:0]       sw_pop;
    logic [COUNT_W-1:0]   used_next;

    // request update
    logic [BIT_W-1:0]     zb;
    logic [BIT_W-1:0]     bsel;
    logic [INDEX_W-1:0]   f_idx;
    logic                 in_range;
    logic                 cur_bit;
    logic [WORD_W-1:0]    one_hot;
    logic [WORD_W-1:0]    new_word;
    logic                 we;
    logic                 inc;
    logic                 dec;
    logic [INDEX_W-1:0]   granted;
    logic [STATUS_W-1:0]  status;
    logic                 alloc_bit;
    logic [COUNT_W-1:0]   next_free;

    assign o_stall     = !i_cmd.in_ready;
    assign o_cfg_ready = i_cmd.cfg_ready;

    assign o_stat.in_beat   = i_valid && i_cmd.in_ready;
    assign o_stat.cfg_beat  = i_cfg_valid && i_cmd.cfg_ready;
    assign o_stat.new_alloc = (i_func == FUNC_ALLOC);
    assign o_stat.out_free  = !r_o_valid || !i_stall;
    assign o_stat.sw_last   = (r_sw_addr == WA'(NW - 1));

    assign eff_limit = (i_cfg_data > LIM_MAX) ? LIM_MAX : i_cfg_data;
    assign sum_pad   = (NG*WORD_W)'(r_nonfull);
    assign word      = r_rd_valid ? r_rdata : '0;

    always_comb begin
        sel_any = 1'b0;
        sel_w7  = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                sel_any = 1'b1;
                sel_w7  = 7'((g * WORD_W) + int'(r_grp_low[g]));
            end
        end
    end

    always_comb begin
        logic [6:0] cand;
        cand = r_idx[INDEX_W-1:BIT_W];
        if (int'(cand) < NW) begin
            idx_word = WA'(cand);
        end else begin
            idx_word = '0;
        end
    end

    always_comb begin
        rd_en = i_cmd.sw_rd || i_cmd.rd_alloc || i_cmd.rd_item;
        if (i_cmd.sw_rd) begin
            rd_addr = r_sw_addr;
        end else if (i_cmd.rd_alloc) begin
            rd_addr = WA'(sel_w7);
        end else begin
            rd_addr = idx_word;
        end
    end

    always_comb begin
        sw_lo   = COUNT_W'(r_sw_addr) << BIT_W;
        sw_hi   = sw_lo + COUNT_W'(WORD_W);
        sw_rem  = r_limit - sw_lo;
        if (r_limit >= sw_hi) begin
            sw_mask = '1;
        end else if (r_limit <= sw_lo) begin
            sw_mask = '0;
        end else begin
            sw_mask = ~({WORD_W{1'b1}} << sw_rem[BIT_W-1:0]);
        end
        sw_pop = '0;
        for (int j = 0; j < WORD_W; j++) begin
            sw_pop = sw_pop + (BIT_W+1)'(word[j] & sw_mask[j]);
        end
        used_next = r_used + COUNT_W'(sw_pop);
    end

    always_comb begin
        zb        = lowest_set(~word);
        bsel      = (r_func == FUNC_ALLOC) ? zb : r_idx[BIT_W-1:0];
        f_idx     = {7'(r_word_addr), zb};
        in_range  = ({1'b0, r_idx} < r_limit);
        cur_bit   = word[bsel];
        one_hot   = WORD_W'(1) << bsel;
        new_word  = word;
        we        = 1'b0;
        inc       = 1'b0;
        dec       = 1'b0;
        granted   = r_idx;
        status    = ST_OK;
        alloc_bit = 1'b0;
        case (r_func)
            FUNC_ALLOC: begin
                if (r_found && ({1'b0, f_idx} < r_limit)) begin
                    we       = 1'b1;
                    new_word = word | one_hot;
                    dec      = 1'b1;
                    granted  = f_idx;
                end else begin
                    granted = '0;
                    status  = ST_NO_FREE;
                end
            end
            FUNC_FREE: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    we       = 1'b1;
                    new_word = word & ~one_hot;
                    inc      = cur_bit;
                end
            end
            FUNC_QUERY: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    alloc_bit = cur_bit;
                end
            end
            FUNC_MARK: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    we       = 1'b1;
                    new_word = word | one_hot;
                    dec      = !cur_bit;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        next_free = r_free + COUNT_W'(inc) - COUNT_W'(dec);
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && we) begin
            mem[r_word_addr] <= new_word;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_valid <= r_wvalid[rd_addr];
        end
        if (i_cmd.rd_alloc || i_cmd.rd_item) begin
            r_word_addr <= rd_addr;
            r_found     <= sel_any;
        end
        if (i_cmd.cap_item) begin
            r_func <= i_func;
            r_idx  <= i_block_index;
        end
        if (i_cmd.grp_load) begin
            for (int g = 0; g < NG; g++) begin
                r_grp_any[g] <= |sum_pad[g*WORD_W +: WORD_W];
                r_grp_low[g] <= lowest_set(sum_pad[g*WORD_W +: WORD_W]);
            end
        end
        if (i_cmd.commit) begin
            r_granted  <= granted;
            r_status   <= status;
            r_is_alloc <= alloc_bit;
            r_o_free   <= next_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid  <= '0;
            r_nonfull <= '1;
            r_limit   <= LIM_MAX;
            r_free    <= '0;
            r_used    <= '0;
            r_sw_addr <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.commit && we) begin
                r_wvalid[r_word_addr]  <= 1'b1;
                r_nonfull[r_word_addr] <= ~&new_word;
            end
            if (o_stat.cfg_beat) begin
                r_limit   <= eff_limit;
                r_used    <= '0;
                r_sw_addr <= '0;
            end else if (i_cmd.sw_acc) begin
                r_used    <= used_next;
                r_sw_addr <= r_sw_addr + WA'(1);
                if (o_stat.sw_last) begin
                    r_free <= r_limit - used_next;
                end
            end
            if (i_cmd.commit) begin
                r_free <= next_free;
            end
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;
    assign o_is_allocated  = r_is_alloc;
    assign o_free_count    = r_o_free;

endmodule
